// ----- rtl/fhc_pkg.sv -----
// Shared types, constants and the fuzzify function of the fuzzy heating controller.
package fhc_pkg;

    localparam int FULL_SCALE = 1024;
    localparam int NUM_SETS = 5;
    localparam int MW = $clog2(FULL_SCALE + 1);
    localparam int PW = 28;
    localparam int MUL_AW = 30;
    localparam int MUL_BW = 17;
    localparam int PRODW = MUL_AW + MUL_BW;
    localparam int NUMW = 30;
    localparam int DENW = $clog2(NUM_SETS * FULL_SCALE + 1);
    localparam int QW = 38;
    localparam int DIV_STEPS = QW / 2;
    localparam int CNTW = $clog2(DIV_STEPS);
    localparam int IDXW = 3;
    localparam int CFG_IW = 4;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] REG_ERR_SCALER = 4'd0;
    localparam logic [CFG_IW-1:0] REG_DERR_SCALER = 4'd1;
    localparam logic [CFG_IW-1:0] REG_OUTPUT_SCALER = 4'd2;
    localparam logic [CFG_IW-1:0] REG_CENTER_OM = 4'd3;
    localparam logic [CFG_IW-1:0] REG_CENTER_OS = 4'd4;
    localparam logic [CFG_IW-1:0] REG_CENTER_ZE = 4'd5;
    localparam logic [CFG_IW-1:0] REG_CENTER_US = 4'd6;
    localparam logic [CFG_IW-1:0] REG_CENTER_UM = 4'd7;

    typedef enum logic [2:0] {
        SET_OM = 3'd0,
        SET_OS = 3'd1,
        SET_ZE = 3'd2,
        SET_US = 3'd3,
        SET_UM = 3'd4
    } set_t;

    typedef enum logic [1:0] {
        MUL_ERR,
        MUL_DERR,
        MUL_WEIGHT,
        MUL_SCALE
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_E,
        ST_MUL_D,
        ST_FUZ_D,
        ST_RULE,
        ST_WMUL,
        ST_WACC,
        ST_SMUL,
        ST_DSET,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic            load;
        logic            mul_en;
        mul_sel_t        mul_sel;
        logic            fuz_err;
        logic            fuz_derr;
        logic            rule_en;
        logic            wacc;
        logic            div_init;
        logic            div_step;
        logic            out_load;
        logic [IDXW-1:0] idx;
    } ctl_t;

    typedef logic [NUM_SETS-1:0][MW-1:0] mv_arr_t;

    localparam set_t RULE_TAB [NUM_SETS][NUM_SETS] = '{
        '{SET_UM, SET_UM, SET_UM, SET_US, SET_ZE},
        '{SET_UM, SET_UM, SET_US, SET_ZE, SET_OS},
        '{SET_UM, SET_US, SET_ZE, SET_OS, SET_OM},
        '{SET_US, SET_ZE, SET_OS, SET_OM, SET_OM},
        '{SET_ZE, SET_OS, SET_OM, SET_OM, SET_OM}
    };

    function automatic mv_arr_t fuzzify(input logic signed [PW-1:0] x);
        logic signed [PW-1:0] f1;
        logic signed [PW-1:0] f2;
        logic signed [PW-1:0] d;
        mv_arr_t mv;
        f1 = PW'(FULL_SCALE);
        f2 = PW'(2 * FULL_SCALE);
        mv = '0;
        if (x < -f2)
        begin
            mv[SET_OM] = MW'(FULL_SCALE);
        end
        else if (x < -f1)
        begin
            d = x + f2;
            mv[SET_OM] = MW'(f1 - d);
            mv[SET_OS] = MW'(d);
        end
        else if (x < 0)
        begin
            d = x + f1;
            mv[SET_OS] = MW'(f1 - d);
            mv[SET_ZE] = MW'(d);
        end
        else if (x < f1)
        begin
            mv[SET_ZE] = MW'(f1 - x);
            mv[SET_US] = MW'(x);
        end
        else if (x < f2)
        begin
            d = x - f1;
            mv[SET_US] = MW'(f1 - d);
            mv[SET_UM] = MW'(d);
        end
        else
        begin
            mv[SET_UM] = MW'(FULL_SCALE);
        end
        return mv;
    endfunction

endpackage

// ----- rtl/fuzzy_heating_controller.sv -----
// Top level of the fuzzy heating controller.
// Each input word passes the shared multiplier and the radix-4 divider in turn; the block takes
// one new word only while it is idle, so a new word waits until the last result is loaded.
// Reset is asynchronous and active low; it loads the register defaults and marks the first step.
module fuzzy_heating_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [15:0]           current_temp,
    input  logic signed [15:0]           setpoint,
    input  logic                         restart,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [23:0]           drive_change,
    output logic                         no_weight,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fhc_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [fhc_pkg::CFG_DW-1:0]   cfg_data
);
    import fhc_pkg::*;

    ctl_t ctl;

    assign cfg_ready = 1'b1;

    fhc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    fhc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .current_temp (current_temp),
        .setpoint     (setpoint),
        .restart      (restart),
        .drive_change (drive_change),
        .no_weight    (no_weight)
    );

endmodule

// ----- rtl/fhc_ctrl.sv -----
// Sequencing state machine of the fuzzy heating controller.
module fhc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output fhc_pkg::ctl_t ctl
);
    import fhc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctl = '0;
        ctl.mul_sel = MUL_ERR;
        ctl.idx = cnt_reg[IDXW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    state_next = ST_MUL_E;
                end
            end
            ST_MUL_E:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = MUL_ERR;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = MUL_DERR;
                ctl.fuz_err = 1'b1;
                state_next = ST_FUZ_D;
            end
            ST_FUZ_D:
            begin
                ctl.fuz_derr = 1'b1;
                cnt_next = '0;
                state_next = ST_RULE;
            end
            ST_RULE:
            begin
                ctl.rule_en = 1'b1;
                if (cnt_reg == CNTW'(NUM_SETS - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_WMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WMUL:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = MUL_WEIGHT;
                state_next = ST_WACC;
            end
            ST_WACC:
            begin
                ctl.wacc = 1'b1;
                if (cnt_reg == CNTW'(NUM_SETS - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_SMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    state_next = ST_WMUL;
                end
            end
            ST_SMUL:
            begin
                ctl.mul_en = 1'b1;
                ctl.mul_sel = MUL_SCALE;
                state_next = ST_DSET;
            end
            ST_DSET:
            begin
                ctl.div_init = 1'b1;
                cnt_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                if (cnt_reg == CNTW'(DIV_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/fhc_datapath.sv -----
// Datapath of the fuzzy heating controller: registers, multiplier, rule unit and divider.
module fhc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fhc_pkg::ctl_t                ctl,
    input  logic                         cfg_valid,
    input  logic [fhc_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [fhc_pkg::CFG_DW-1:0]   cfg_data,
    input  logic signed [15:0]           current_temp,
    input  logic signed [15:0]           setpoint,
    input  logic                         restart,
    output logic signed [23:0]           drive_change,
    output logic                         no_weight
);
    import fhc_pkg::*;

    logic [9:0] err_scaler_reg;
    logic [9:0] derr_scaler_reg;
    logic [7:0] output_scaler_reg;
    logic signed [15:0] center_reg [NUM_SETS];

    logic first_reg;
    logic signed [16:0] prev_reg;
    logic signed [16:0] err_reg;
    logic signed [17:0] derr_reg;
    logic signed [PRODW-1:0] prod_reg;
    mv_arr_t m1_reg;
    mv_arr_t m2_reg;
    logic [MW-1:0] ov_reg [NUM_SETS];
    logic signed [NUMW-1:0] num_reg;
    logic [DENW-1:0] den_reg;
    logic neg_reg;
    logic [DENW:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic signed [23:0] drive_reg;
    logic no_weight_reg;

    logic signed [16:0] err_new;
    logic signed [17:0] derr_new;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic [MW-1:0] best;
    logic [MW-1:0] mn;
    logic [IDXW-1:0] bidx;
    set_t rule_o;
    logic [MW:0] ov_sum;
    logic [MW-1:0] ov_clamped;
    logic [DENW:0] rem_step;
    logic [QW-1:0] quo_step;
    logic [QW-1:0] prod_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_scaler_reg <= 10'd1;
            derr_scaler_reg <= 10'd1;
            output_scaler_reg <= 8'd1;
            center_reg[SET_OM] <= -16'sd2048;
            center_reg[SET_OS] <= -16'sd1024;
            center_reg[SET_ZE] <= 16'sd0;
            center_reg[SET_US] <= 16'sd1024;
            center_reg[SET_UM] <= 16'sd2048;
            first_reg <= 1'b1;
            prev_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ERR_SCALER: err_scaler_reg <= cfg_data[9:0];
                    REG_DERR_SCALER: derr_scaler_reg <= cfg_data[9:0];
                    REG_OUTPUT_SCALER: output_scaler_reg <= cfg_data[7:0];
                    REG_CENTER_OM: center_reg[SET_OM] <= cfg_data;
                    REG_CENTER_OS: center_reg[SET_OS] <= cfg_data;
                    REG_CENTER_ZE: center_reg[SET_ZE] <= cfg_data;
                    REG_CENTER_US: center_reg[SET_US] <= cfg_data;
                    REG_CENTER_UM: center_reg[SET_UM] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.load)
            begin
                first_reg <= 1'b0;
                prev_reg <= err_new;
            end
        end
    end

    assign err_new = 17'(setpoint) - 17'(current_temp);
    assign derr_new = (first_reg || restart) ? 18'sd0 : 18'(err_new) - 18'(prev_reg);

    always_comb
    begin
        case (ctl.mul_sel)
            MUL_ERR:
            begin
                mul_a = MUL_AW'(err_reg);
                mul_b = MUL_BW'($signed({1'b0, err_scaler_reg}));
            end
            MUL_DERR:
            begin
                mul_a = MUL_AW'(derr_reg);
                mul_b = MUL_BW'($signed({1'b0, derr_scaler_reg}));
            end
            MUL_WEIGHT:
            begin
                mul_a = MUL_AW'($signed({1'b0, ov_reg[ctl.idx]}));
                mul_b = MUL_BW'(center_reg[ctl.idx]);
            end
            MUL_SCALE:
            begin
                mul_a = num_reg;
                mul_b = MUL_BW'($signed({1'b0, output_scaler_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        best = '0;
        bidx = '0;
        for (int j = 0; j < NUM_SETS; j++)
        begin
            mn = (m1_reg[ctl.idx] < m2_reg[j]) ? m1_reg[ctl.idx] : m2_reg[j];
            if (j == 0 || best < mn)
            begin
                best = mn;
                bidx = IDXW'(j);
            end
        end
        rule_o = RULE_TAB[ctl.idx][bidx];
        ov_sum = {1'b0, ov_reg[rule_o]} + {1'b0, best};
        ov_clamped = (ov_sum > (MW + 1)'(FULL_SCALE)) ? MW'(FULL_SCALE) : ov_sum[MW-1:0];
    end

    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            rem_step = {rem_step[DENW-1:0], quo_step[QW-1]};
            quo_step = {quo_step[QW-2:0], 1'b0};
            if (rem_step >= {1'b0, den_reg})
            begin
                rem_step = rem_step - {1'b0, den_reg};
                quo_step[0] = 1'b1;
            end
        end
    end

    assign prod_mag = prod_reg[PRODW-1] ? QW'(-prod_reg) : QW'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            err_reg <= err_new;
            derr_reg <= derr_new;
            num_reg <= '0;
            den_reg <= '0;
            for (int i = 0; i < NUM_SETS; i++)
            begin
                ov_reg[i] <= '0;
            end
        end
        if (ctl.mul_en)
        begin
            prod_reg <= PRODW'(mul_a) * PRODW'(mul_b);
        end
        if (ctl.fuz_err)
        begin
            m1_reg <= fuzzify(prod_reg[PW-1:0]);
        end
        if (ctl.fuz_derr)
        begin
            m2_reg <= fuzzify(prod_reg[PW-1:0]);
        end
        if (ctl.rule_en)
        begin
            ov_reg[rule_o] <= ov_clamped;
        end
        if (ctl.wacc)
        begin
            num_reg <= num_reg + prod_reg[NUMW-1:0];
            den_reg <= den_reg + DENW'(ov_reg[ctl.idx]);
        end
        if (ctl.div_init)
        begin
            neg_reg <= prod_reg[PRODW-1];
            quo_reg <= prod_mag;
            rem_reg <= '0;
        end
        if (ctl.div_step)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
        if (ctl.out_load)
        begin
            if (den_reg == '0)
            begin
                drive_reg <= '0;
                no_weight_reg <= 1'b1;
            end
            else
            begin
                drive_reg <= neg_reg ? quo_reg[23:0] : -quo_reg[23:0];
                no_weight_reg <= 1'b0;
            end
        end
    end

    assign drive_change = drive_reg;
    assign no_weight = no_weight_reg;

endmodule

// ----- rtl/fhc_checker.sv -----
// Port-level checker of the fuzzy heating controller and its bind statement.
module fhc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [23:0] drive_change,
    input logic               no_weight
);

    // A stalled result word stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(drive_change) && $stable(no_weight))
        else $error("result word changed while stalled");

    // A word with no weight always carries a zero drive change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_weight |-> drive_change == 24'sd0)
        else $error("nonzero drive change with no weight");

    // Once a word is taken, the input side is held off while it is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a word");

    // A result cannot appear in the cycle right after an input word is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind fuzzy_heating_controller fhc_checker u_fhc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_change (drive_change),
    .no_weight    (no_weight)
);
